FILE: rtl/core/sipq_pkg.sv
// Shared types, constants and helpers for the sorted insert priority queue.
package sipq_pkg;

    // Queue geometry.
    localparam int DEPTH       = 16;
    localparam int WEIGHT_BITS = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef logic signed [WEIGHT_BITS-1:0] t_weight;

    typedef struct packed {
        t_weight    weight;
        logic [7:0] symbol;
    } t_entry;

    // Load select for one cell of the chain.
    typedef logic [1:0] t_cell_sel;
    localparam t_cell_sel SEL_KEEP = 2'd0;
    localparam t_cell_sel SEL_PREV = 2'd1;
    localparam t_cell_sel SEL_NEW  = 2'd2;
    localparam t_cell_sel SEL_NEXT = 2'd3;

    // Request opcodes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_DROPPED  = 2'd1;
    localparam logic [1:0] STAT_READOUT  = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    // Sign-extends or wraps a 32-bit weight to the stored weight width.
    function automatic t_weight to_weight(input logic signed [31:0] w);
        return WEIGHT_BITS'(w);
    endfunction

endpackage

FILE: rtl/core/sipq_cell.sv
// One storage cell of the sorted chain: holds one entry and compares it with the new weight.
module sipq_cell import sipq_pkg::*; (
    input  logic      i_clk,
    input  t_cell_sel i_sel,
    input  t_entry    i_prev,
    input  t_entry    i_next,
    input  t_entry    i_new,
    output t_entry    o_entry,
    output logic      o_gt
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        case (i_sel)
            SEL_PREV: n_entry = i_prev;
            SEL_NEW:  n_entry = i_new;
            SEL_NEXT: n_entry = i_next;
            default:  n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // The held entry must move up when it is strictly heavier than the new one.
    assign o_gt    = $signed(r_entry.weight) > $signed(i_new.weight);
    assign o_entry = r_entry;

endmodule

FILE: rtl/core/sorted_insert_priority_queue_top.sv
// Top level of the sorted insert priority queue: a chain of cells with a dump sequencer.
//
//   channel   direction  handshake                   payload
//   request   in         i_in_valid / o_in_stall     i_opcode, i_new_weight, i_new_symbol
//   result    out        o_out_valid / i_out_stall   o_status, o_entry_weight, o_entry_symbol,
//                                                    o_entry_position, o_fill_count,
//                                                    o_last_of_run
//
// On an insert every cell compares its weight with the new weight in
// parallel, heavier cells shift one place up the chain and the new entry drops into the gap.
// On a dump of N entries the occupied part of the chain rotates one place per
// result towards cell 0, which feeds the result register, and after N steps it is back in order.
// A dump of an empty queue and a dropped insert each give one result.
// Reset is synchronous and active low; it empties the queue and clears the result valid.
// A stalled result holds the result register, and o_in_stall stays high for the whole dump.
module sorted_insert_priority_queue_top import sipq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic signed [31:0] i_new_weight,
    input  logic [7:0]         i_new_symbol,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_entry_weight,
    output logic [7:0]         o_entry_symbol,
    output logic [3:0]         o_entry_position,
    output logic [4:0]         o_fill_count,
    output logic               o_last_of_run
);

    // Sequencer states.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic             r_state;
    logic [IDX_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_occ;
    logic             r_out_valid;

    logic [1:0]         r_stat;
    logic signed [31:0] r_weight;
    logic [7:0]         r_symbol;
    logic [3:0]         r_pos;
    logic [4:0]         r_fill;
    logic               r_last;

    logic [1:0]         n_stat;
    logic signed [31:0] n_weight;
    logic [7:0]         n_symbol;
    logic [3:0]         n_pos;
    logic [4:0]         n_fill;
    logic               n_last;

    t_entry           w_new;
    t_entry           w_cell [DEPTH];
    t_cell_sel        w_sel  [DEPTH];
    logic [DEPTH-1:0] w_gt;
    logic [DEPTH-1:0] w_move;
    logic [DEPTH-1:0] w_ins_pt;
    logic [IDX_W-1:0] w_ins_pos;

    logic             w_out_free;
    logic             w_accept;
    logic             w_full;
    logic             w_do_ins;
    logic             w_dump_first;
    logic             w_dump_next;
    logic             w_do_rot;
    logic [IDX_W-1:0] w_rd_idx;
    logic             w_rd_last;

    // The result register can take a new result when it is empty or being drained.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state == ST_DUMP) || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_occ == CNT_W'(DEPTH));

    assign w_do_ins     = w_accept && (i_opcode == OP_INSERT) && !w_full;
    assign w_dump_first = w_accept && (i_opcode == OP_DUMP) && (r_occ != '0);
    assign w_dump_next  = (r_state == ST_DUMP) && w_out_free;
    assign w_do_rot     = w_dump_first || w_dump_next;

    // Rank of the entry now sitting in cell 0 during a dump.
    assign w_rd_idx  = (r_state == ST_DUMP) ? r_cnt : '0;
    assign w_rd_last = ((CNT_W'(w_rd_idx) + CNT_W'(1)) == r_occ);

    assign w_new = '{weight: to_weight(i_new_weight), symbol: i_new_symbol};

    // The chain. Cell i moves up on an insert when it is occupied and heavier than the
    // new entry; since the chain is sorted, the moving cells form one run up to the fill
    // level, and the new entry lands in the first cell that is moving or empty.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic   w_occupied;
        logic   w_at_end;
        logic   w_prev_move;
        t_entry w_prev_data;
        t_entry w_next_data;

        assign w_occupied  = (CNT_W'(gi) < r_occ);
        assign w_at_end    = (CNT_W'(gi) == r_occ);
        assign w_move[gi]  = w_occupied && w_gt[gi];

        if (gi == 0) begin : g_head
            assign w_prev_move = 1'b0;
            assign w_prev_data = w_new;
        end else begin : g_body
            assign w_prev_move = w_move[gi-1];
            assign w_prev_data = w_cell[gi-1];
        end

        // During a dump the last occupied cell takes the head entry, closing the ring.
        if (gi == DEPTH - 1) begin : g_tail
            assign w_next_data = w_cell[0];
        end else begin : g_inner
            assign w_next_data = (CNT_W'(gi + 1) == r_occ) ? w_cell[0] : w_cell[gi+1];
        end

        assign w_ins_pt[gi] = (w_move[gi] || w_at_end) && !w_prev_move;

        always_comb begin
            w_sel[gi] = SEL_KEEP;
            if (w_do_ins) begin
                if (w_prev_move) begin
                    w_sel[gi] = SEL_PREV;
                end else if (w_move[gi] || w_at_end) begin
                    w_sel[gi] = SEL_NEW;
                end
            end else if (w_do_rot && w_occupied) begin
                w_sel[gi] = SEL_NEXT;
            end
        end

        sipq_cell u_cell (
            .i_clk   (i_clk),
            .i_sel   (w_sel[gi]),
            .i_prev  (w_prev_data),
            .i_next  (w_next_data),
            .i_new   (w_new),
            .o_entry (w_cell[gi]),
            .o_gt    (w_gt[gi])
        );
    end

    // Exactly one insertion point exists when the queue is not full; encode its index.
    always_comb begin
        w_ins_pos = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_ins_pt[k]) begin
                w_ins_pos = w_ins_pos | IDX_W'(k);
            end
        end
    end

    // Next result.
    always_comb begin
        n_stat   = STAT_EMPTY;
        n_weight = '0;
        n_symbol = '0;
        n_pos    = '0;
        n_fill   = 5'(r_occ);
        n_last   = 1'b1;
        if (w_do_rot) begin
            n_stat   = STAT_READOUT;
            n_weight = 32'(w_cell[0].weight);
            n_symbol = w_cell[0].symbol;
            n_pos    = 4'(w_rd_idx);
            n_last   = w_rd_last;
        end else if (i_opcode == OP_INSERT) begin
            if (w_full) begin
                n_stat = STAT_DROPPED;
            end else begin
                n_stat = STAT_INSERTED;
                n_pos  = 4'(w_ins_pos);
                n_fill = 5'(r_occ + CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= w_accept || w_dump_next;
            end
            if (w_do_ins) begin
                r_occ <= r_occ + CNT_W'(1);
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_dump_first && !w_rd_last) begin
                        r_state <= ST_DUMP;
                        r_cnt   <= IDX_W'(1);
                    end
                end
                ST_DUMP: begin
                    if (w_dump_next) begin
                        if (w_rd_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_cnt <= r_cnt + IDX_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Result payload; loaded only together with a new result.
    always_ff @(posedge i_clk) begin
        if (w_out_free && (w_accept || w_dump_next)) begin
            r_stat   <= n_stat;
            r_weight <= n_weight;
            r_symbol <= n_symbol;
            r_pos    <= n_pos;
            r_fill   <= n_fill;
            r_last   <= n_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_stat;
    assign o_entry_weight   = r_weight;
    assign o_entry_symbol   = r_symbol;
    assign o_entry_position = r_pos;
    assign o_fill_count     = r_fill;
    assign o_last_of_run    = r_last;

`ifndef NO_ASSERTIONS
    // The fill level never passes the number of cells.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(DEPTH))
        else $error("queue fill level above depth");

    // A dump in progress always reads an occupied cell.
    a_dump_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |-> (r_occ != '0) && (CNT_W'(r_cnt) < r_occ))
        else $error("dump rank outside the occupied cells");

    // A stored insert grows the queue by exactly one entry.
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_ins |=> (r_occ == $past(r_occ) + CNT_W'(1)))
        else $error("insert did not grow the queue by one");

    // A request is never taken while the result register is full and held.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_accept && !w_dump_next)
        else $error("result overwritten while stalled");
`endif

endmodule

FILE: tb/sipq_checker.sv
// Checker for the sorted insert priority queue: predicts every result and compares it.
`timescale 1ns / 100ps

module sipq_checker import sipq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_opcode,
    input  logic signed [31:0] i_new_weight,
    input  logic [7:0]         i_new_symbol,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_status,
    input  logic signed [31:0] i_entry_weight,
    input  logic [7:0]         i_entry_symbol,
    input  logic [3:0]         i_entry_position,
    input  logic [4:0]         i_fill_count,
    input  logic               i_last_of_run,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] weight;
        logic [7:0]  symbol;
        logic [3:0]  position;
        logic [4:0]  fill;
        logic        last;
    } t_result;

    // Shadow copy of the sorted list.
    t_weight    sorted_weight [DEPTH];
    logic [7:0] sorted_symbol [DEPTH];
    int         entry_count;

    t_result queued_results[$];
    int      mismatch_count;

    function automatic t_result make_result(input logic [1:0] status, input logic [31:0] weight,
                                            input logic [7:0] symbol, input int position,
                                            input int fill, input logic last);
        t_result r;
        r.status   = status;
        r.weight   = weight;
        r.symbol   = symbol;
        r.position = 4'(position);
        r.fill     = 5'(fill);
        r.last     = last;
        return r;
    endfunction

    // Applies one accepted request to the shadow list and queues the results it causes.
    task automatic apply_request(input logic opcode, input logic signed [31:0] weight_in,
                                 input logic [7:0] symbol_in);
        t_weight weight;
        int      slot;
        int      k;
        weight = t_weight'(weight_in);
        if (opcode == OP_INSERT) begin
            if (entry_count >= DEPTH) begin
                queued_results.push_back(make_result(STAT_DROPPED, '0, '0, 0, entry_count, 1'b1));
            end else begin
                // The new entry goes after every entry of equal or smaller weight.
                slot = 0;
                while (slot < entry_count && sorted_weight[slot] <= weight)
                    slot++;
                for (k = entry_count; k > slot; k--) begin
                    sorted_weight[k] = sorted_weight[k-1];
                    sorted_symbol[k] = sorted_symbol[k-1];
                end
                sorted_weight[slot] = weight;
                sorted_symbol[slot] = symbol_in;
                entry_count++;
                queued_results.push_back(make_result(STAT_INSERTED, '0, '0, slot, entry_count,
                                                     1'b1));
            end
        end else if (entry_count == 0) begin
            queued_results.push_back(make_result(STAT_EMPTY, '0, '0, 0, 0, 1'b1));
        end else begin
            for (k = 0; k < entry_count; k++)
                queued_results.push_back(make_result(STAT_READOUT, 32'(sorted_weight[k]),
                                                     sorted_symbol[k], k, entry_count,
                                                     k == entry_count - 1));
        end
    endtask

    task automatic compare_result(input t_result seen);
        t_result want;
        if (queued_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: unexpected result status %0d weight %0d symbol %0d",
                         $time, seen.status, $signed(seen.weight), seen.symbol,
                         " pos %0d fill %0d last %0d",
                         seen.position, seen.fill, seen.last);
            return;
        end
        want = queued_results.pop_front();
        if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: result mismatch: expected status %0d weight %0d symbol %0d",
                         $time, want.status, $signed(want.weight), want.symbol,
                         " pos %0d fill %0d last %0d,",
                         want.position, want.fill, want.last,
                         " got status %0d weight %0d symbol %0d",
                         seen.status, $signed(seen.weight), seen.symbol,
                         " pos %0d fill %0d last %0d",
                         seen.position, seen.fill, seen.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_count = 0;
            queued_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                apply_request(i_opcode, i_new_weight, i_new_symbol);
            if (i_out_valid && !i_out_stall)
                compare_result(make_result(i_status, i_entry_weight, i_entry_symbol,
                                           i_entry_position, i_fill_count, i_last_of_run));
        end
        o_fail_count = mismatch_count;
        o_pending    = queued_results.size();
    end

endmodule

FILE: tb/sorted_insert_priority_queue_top_tb.sv
// Testbench top for the sorted insert priority queue: stimulus, receiver pacing and verdict.
`timescale 1ns / 100ps

module sorted_insert_priority_queue_top_tb import sipq_pkg::*; ();

    // Every input of the block starts at a known value.
    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               i_opcode     = OP_INSERT;
    logic signed [31:0] i_new_weight = '0;
    logic [7:0]         i_new_symbol = '0;
    logic               i_out_stall  = 1'b0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_entry_weight;
    logic [7:0]         o_entry_symbol;
    logic [3:0]         o_entry_position;
    logic [4:0]         o_fill_count;
    logic               o_last_of_run;

    int fail_count;
    int results_pending;

    // While steady_flow is set, neither side idles, giving stretches of full-rate traffic.
    logic steady_flow = 1'b0;

    // The stimulus asks for a long receiver hold-off by bumping hold_asked; the receiver
    // process notices the change and counts the hold-off down on its own.
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left  = 0;
    int run_left   = 0;
    logic run_stalled = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sorted_insert_priority_queue_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_new_weight     (i_new_weight),
        .i_new_symbol     (i_new_symbol),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_entry_weight   (o_entry_weight),
        .o_entry_symbol   (o_entry_symbol),
        .o_entry_position (o_entry_position),
        .o_fill_count     (o_fill_count),
        .o_last_of_run    (o_last_of_run)
    );

    sipq_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_new_weight     (i_new_weight),
        .i_new_symbol     (i_new_symbol),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_status         (o_status),
        .i_entry_weight   (o_entry_weight),
        .i_entry_symbol   (o_entry_symbol),
        .i_entry_position (o_entry_position),
        .i_fill_count     (o_fill_count),
        .i_last_of_run    (o_last_of_run),
        .o_fail_count     (fail_count),
        .o_pending        (results_pending)
    );

    // Idle stretch length: mostly short, now and then a long one.
    function automatic int idle_length();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Weight mix: small values around zero give many ties, which is where the arrival
    // order rule matters; the rest are extremes, single bits and full random words.
    function automatic logic signed [31:0] pick_weight();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 4) - 2;
            1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2:       return 32'sd1 <<< $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Receiver pacing. The stall changes only at the falling edge. A requested hold-off
    // overrides all; a steady flow holds the stall low; else stall runs and ready runs mix.
    always @(negedge i_clk) begin
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left  = 150;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (steady_flow) begin
            run_left = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (run_left == 0) begin
                run_stalled = ($urandom_range(0, 2) == 0);
                run_left    = run_stalled ? idle_length() : $urandom_range(1, 8);
            end
            run_left--;
            i_out_stall <= run_stalled;
        end
    end

    // Offers one request, after a random gap unless the flow is steady, and returns at the
    // rising edge where the block takes it. Valid stays high into the next call, so a
    // back-to-back request never sees valid drop and rise within one time step.
    task automatic send_request(input logic opcode, input logic signed [31:0] weight,
                                input logic [7:0] symbol);
        int gap;
        gap = (steady_flow || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= opcode;
        i_new_weight <= weight;
        i_new_symbol <= symbol;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drops valid and waits until every predicted result has been seen, then waits on
    // so that a stray extra result would still be caught.
    task automatic wait_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (results_pending != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A dump of the empty queue comes first, then the weight extremes,
        // zero twice to check that ties keep their arrival order, and minus one.
        send_request(OP_DUMP,   '0,           8'h00);
        send_request(OP_INSERT, 32'sh7FFF_FFFF, 8'hFF);
        send_request(OP_INSERT, 32'sh8000_0000, 8'h00);
        send_request(OP_INSERT, 32'sd0,       8'h55);
        send_request(OP_INSERT, 32'sd0,       8'hAA);
        send_request(OP_INSERT, -32'sd1,      8'h0F);
        send_request(OP_DUMP,   '0,           8'h00);

        // The queue never shrinks, so the rest of the sixteen inserts are spent here with
        // mixed weights, dumping partway through to see intermediate orderings.
        for (int n = 5; n < DEPTH; n++) begin
            send_request(OP_INSERT, pick_weight(), 8'($urandom_range(0, 255)));
            if (n == 10)
                send_request(OP_DUMP, '0, 8'h00);
        end

        // The queue is full now: this insert is dropped and flagged, and the dump reads
        // out the whole list.
        send_request(OP_INSERT, 32'sd7, 8'h3C);
        send_request(OP_DUMP,   '0,     8'h00);

        // Random part. Every insert is dropped from here on, so the traffic mixes dropped
        // inserts with full dumps under varying pacing on both sides.
        for (int n = 0; n < 100; n++) begin
            if (n == 30) begin
                // Long receiver hold-off while the sender keeps offering requests
                // back to back, so the block's output backs up and it stalls its input.
                hold_asked  = hold_asked + 1;
                steady_flow = 1'b1;
            end else if (n == 42) begin
                steady_flow = 1'b0;
            end else if (n == 60) begin
                // Sender pause until the block has delivered every result.
                wait_until_drained();
            end else if (n == 80) begin
                steady_flow = 1'b1;
            end else if (n == 95) begin
                steady_flow = 1'b0;
            end
            if ($urandom_range(0, 99) < 35)
                send_request(OP_DUMP, $urandom, 8'($urandom_range(0, 255)));
            else
                send_request(OP_INSERT, pick_weight(), 8'($urandom_range(0, 255)));
        end

        wait_until_drained();
        if (fail_count == 0 && results_pending == 0)
            $display("PASS sorted_insert_priority_queue_top");
        else
            $display("FAIL sorted_insert_priority_queue_top");
        $finish;
    end

    // Timeout well beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("FAIL sorted_insert_priority_queue_top");
        $finish;
    end

endmodule
